// ===== sv/tltpq_pkg.sv =====
package tltpq_pkg;

  typedef enum logic [1:0] {
    ACT_REGISTER = 2'd0,
    ACT_SET      = 2'd1,
    ACT_SERVE    = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_LEVEL = 3'd4
  } status_t;

  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_MED  = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;
  localparam logic [1:0] LVL_BAD  = 2'd3;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_EXEC,
    FSM_FIX,
    FSM_OUT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic exec;
    logic fix_start;
    logic fix_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic fix_last;
    logic need_fix;
  } dp_stat_t;

endpackage

// ===== sv/tltpq_if.sv =====
interface tltpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] item_id;
  logic [10:0] arrival_minute;
  logic [15:0] carried_value;
  logic [1:0]  new_level;
  modport source (output valid, action, item_id, arrival_minute, carried_value, new_level,
                  input ready);
  modport sink (input valid, action, item_id, arrival_minute, carried_value, new_level,
                output ready);
endinterface

interface tltpq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_id;
  logic [10:0] out_minute;
  logic [15:0] out_value;
  logic [1:0]  out_level;
  modport source (output valid, status, out_id, out_minute, out_value, out_level,
                  input ready);
  modport sink (input valid, status, out_id, out_minute, out_value, out_level,
                output ready);
endinterface

// ===== sv/three_level_timed_priority_queue_top.sv =====
// channel | dir | handshake       | payload
// in_     | in  | valid/ready     | action, item_id, arrival_minute, carried_value, new_level
// out_    | out | valid/ready     | status, out_id, out_minute, out_value, out_level
// Each transaction is accepted, scanned over all CAPACITY slots and executed; a set level
// that finds its item with a valid level, or a serve that finds one, then runs a fix-up pass
// over the slots; the result is then offered on out_. Both passes walk the table in order.
// Reset is synchronous, active low, and clears all slot valid bits.
// One transaction is in flight at a time; a stalled result holds until taken.
module three_level_timed_priority_queue_top
  import tltpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic         clk,
  input logic         rst_n,
  tltpq_in_if.sink    in_ch,
  tltpq_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tltpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tltpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_action         (in_ch.action),
    .in_item_id        (in_ch.item_id),
    .in_arrival_minute (in_ch.arrival_minute),
    .in_carried_value  (in_ch.carried_value),
    .in_new_level      (in_ch.new_level),
    .out_status        (out_ch.status),
    .out_id            (out_ch.out_id),
    .out_minute        (out_ch.out_minute),
    .out_value         (out_ch.out_value),
    .out_level         (out_ch.out_level)
  );

endmodule

// ===== sv/tltpq_ctrl.sv =====
module tltpq_ctrl
  import tltpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_SCAN;
      FSM_SCAN: if (stat.scan_last) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = stat.need_fix ? FSM_FIX : FSM_OUT;
      FSM_FIX:  if (stat.fix_last) state_nxt = FSM_OUT;
      FSM_OUT:  if (out_ready) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready       = 1'b1;
        cmd.load       = in_valid;
        cmd.scan_start = in_valid;
      end
      FSM_SCAN: cmd.scan_step = 1'b1;
      FSM_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.fix_start = 1'b1;
      end
      FSM_FIX:  cmd.fix_step = 1'b1;
      FSM_OUT:  out_valid = 1'b1;
      default:  ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_scan_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == FSM_SCAN) else $error("scan not started");

endmodule

// ===== sv/tltpq_dp.sv =====
module tltpq_dp
  import tltpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_item_id,
  input  logic [10:0] in_arrival_minute,
  input  logic [15:0] in_carried_value,
  input  logic [1:0]  in_new_level,
  output logic [2:0]  out_status,
  output logic [15:0] out_id,
  output logic [10:0] out_minute,
  output logic [15:0] out_value,
  output logic [1:0]  out_level
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int RW = $clog2(CAPACITY + 1);

  logic [CAPACITY-1:0] valid_r;
  logic [1:0]          level_r [CAPACITY];
  logic [10:0]         minute_r[CAPACITY];
  logic [15:0]         pay_r   [CAPACITY];
  logic [15:0]         key_r   [CAPACITY];
  logic [RW-1:0]       rank_r  [CAPACITY];

  logic [1:0]  act_r;
  logic [15:0] id_r;
  logic [10:0] min_r;
  logic [15:0] val_r;
  logic [1:0]  nlv_r;

  logic [IW-1:0] idx_r;
  logic          best_ok_r;
  logic [IW-1:0] best_r;
  logic [1:0]    best_lvl_r;
  logic [10:0]   best_min_r;
  logic [RW-1:0] best_rank_r;
  logic          free_ok_r;
  logic [IW-1:0] free_r;
  logic [RW-1:0] cnt_r;

  // unlink / rank fix-up pass
  logic [IW-1:0] tgt_r;
  logic [1:0]    ulvl_r;
  logic [10:0]   umin_r;
  logic [RW-1:0] urank_r;

  logic [2:0]  st_r;
  logic [15:0] oid_r;
  logic [10:0] omin_r;
  logic [15:0] oval_r;
  logic [1:0]  olvl_r;

  logic [2:0]  st_nxt;
  logic [15:0] oid_nxt;
  logic [10:0] omin_nxt;
  logic [15:0] oval_nxt;
  logic [1:0]  olvl_nxt;

  logic          cand;
  logic          better;
  logic [1:0]    ci_lvl;
  logic [10:0]   ci_min;
  logic [RW-1:0] ci_rank;
  logic          last_idx;
  logic          found;
  logic [1:0]    tlvl;
  logic [10:0]   tmin;

  assign ci_lvl   = level_r[idx_r];
  assign ci_min   = minute_r[idx_r];
  assign ci_rank  = rank_r[idx_r];
  assign last_idx = (idx_r == IW'(CAPACITY - 1));

  always_comb begin
    cand = 1'b0;
    unique case (action_t'(act_r))
      ACT_SET:   cand = valid_r[idx_r] && key_r[idx_r] == id_r;
      ACT_SERVE: cand = valid_r[idx_r];
      default:   cand = 1'b0;
    endcase
  end

  // set: lower level wins; serve: higher level wins; then minute, then rank
  always_comb begin
    better = 1'b0;
    if (!best_ok_r) begin
      better = 1'b1;
    end else if (ci_lvl != best_lvl_r) begin
      better = (action_t'(act_r) == ACT_SET) ? (ci_lvl < best_lvl_r) : (ci_lvl > best_lvl_r);
    end else if (ci_min != best_min_r) begin
      better = ci_min < best_min_r;
    end else begin
      better = ci_rank < best_rank_r;
    end
  end

  assign found = best_ok_r;
  assign tlvl  = (action_t'(act_r) == ACT_REGISTER) ? LVL_LOW : nlv_r;
  assign tmin  = (action_t'(act_r) == ACT_REGISTER) ? min_r : best_min_r;

  assign stat.scan_last = last_idx;
  assign stat.fix_last  = last_idx;
  assign stat.need_fix  = found && ((action_t'(act_r) == ACT_SET && nlv_r != LVL_BAD) ||
                                    action_t'(act_r) == ACT_SERVE);

  always_comb begin
    st_nxt   = ST_OK;
    oid_nxt  = '0;
    omin_nxt = '0;
    oval_nxt = '0;
    olvl_nxt = '0;
    unique case (action_t'(act_r))
      ACT_REGISTER: begin
        if (!free_ok_r) st_nxt = ST_FULL;
      end
      ACT_SET: begin
        if (nlv_r == LVL_BAD) begin
          st_nxt = ST_BAD_LEVEL;
        end else if (!found) begin
          st_nxt = ST_NOT_FOUND;
        end else begin
          olvl_nxt = nlv_r;
        end
      end
      ACT_SERVE: begin
        if (!found) begin
          st_nxt = ST_EMPTY;
        end else begin
          oid_nxt  = key_r[best_r];
          omin_nxt = best_min_r;
          oval_nxt = pay_r[best_r];
          olvl_nxt = best_lvl_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (cmd.load) begin
        act_r <= in_action;
        id_r  <= in_item_id;
        min_r <= in_arrival_minute;
        val_r <= in_carried_value;
        nlv_r <= in_new_level;
      end
      if (cmd.scan_start) begin
        idx_r     <= '0;
        best_ok_r <= 1'b0;
        free_ok_r <= 1'b0;
        cnt_r     <= '0;
      end
      if (cmd.scan_step) begin
        if (cand && better) begin
          best_ok_r   <= 1'b1;
          best_r      <= idx_r;
          best_lvl_r  <= ci_lvl;
          best_min_r  <= ci_min;
          best_rank_r <= ci_rank;
        end
        if (!valid_r[idx_r] && !free_ok_r) begin
          free_ok_r <= 1'b1;
          free_r    <= idx_r;
        end
        if (valid_r[idx_r] && ci_lvl == LVL_LOW && ci_min == min_r) begin
          cnt_r <= cnt_r + RW'(1);
        end
        idx_r <= last_idx ? '0 : idx_r + IW'(1);
      end
      if (cmd.exec) begin
        oid_r   <= oid_nxt;
        omin_r  <= omin_nxt;
        oval_r  <= oval_nxt;
        olvl_r  <= olvl_nxt;
        st_r    <= st_nxt;
        tgt_r   <= best_r;
        ulvl_r  <= best_lvl_r;
        umin_r  <= best_min_r;
        urank_r <= best_rank_r;
        cnt_r   <= '0;
        unique case (action_t'(act_r))
          ACT_REGISTER: begin
            if (free_ok_r) begin
              valid_r[free_r]  <= 1'b1;
              level_r[free_r]  <= LVL_LOW;
              minute_r[free_r] <= min_r;
              pay_r[free_r]    <= val_r;
              key_r[free_r]    <= id_r;
              rank_r[free_r]   <= cnt_r;
            end
          end
          ACT_SET: begin
            if (nlv_r != LVL_BAD && found) begin
              valid_r[best_r] <= 1'b0;
            end
          end
          ACT_SERVE: begin
            if (found) begin
              valid_r[best_r] <= 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.fix_step) begin
        if (valid_r[idx_r] && ci_lvl == ulvl_r && ci_min == umin_r && ci_rank > urank_r) begin
          rank_r[idx_r] <= ci_rank - RW'(1);
        end
        if (valid_r[idx_r] && ci_lvl == tlvl && ci_min == tmin &&
            !(ci_lvl == ulvl_r && ci_min == umin_r && ci_rank > urank_r)) begin
          cnt_r <= cnt_r + RW'(1);
        end else if (valid_r[idx_r] && ci_lvl == tlvl && ci_min == tmin) begin
          cnt_r <= cnt_r + RW'(1);
        end
        idx_r <= last_idx ? '0 : idx_r + IW'(1);
        if (last_idx && action_t'(act_r) == ACT_SET) begin
          valid_r[tgt_r] <= 1'b1;
          level_r[tgt_r] <= nlv_r;
          rank_r[tgt_r]  <= (valid_r[idx_r] && ci_lvl == tlvl && ci_min == tmin)
                            ? cnt_r + RW'(1) : cnt_r;
        end
      end
    end
  end

  assign out_status = st_r;
  assign out_id     = oid_r;
  assign out_minute = omin_r;
  assign out_value  = oval_r;
  assign out_level  = olvl_r;

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && action_t'(act_r) == ACT_REGISTER && &valid_r |=> st_r == ST_FULL)
    else $error("full not reported");
  a_serve_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && action_t'(act_r) == ACT_SERVE && found |=> !valid_r[$past(best_r)])
    else $error("served slot still valid");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && action_t'(act_r) == ACT_SERVE && valid_r == '0 |=> st_r == ST_EMPTY)
    else $error("empty not reported");

endmodule
